@@ sv/prfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prfc_pkg
// Shared types and constants for the FIFO / clock page replacement core.
// ----------------------------------------------------------------------------
package prfc_pkg;

   localparam int FRAMES_DEF    = 128;
   localparam int PAGE_BITS_DEF = 12;
   localparam int SLOT_BITS     = 7;
   localparam int CSR_DATA_BITS = 8;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAMES = 1'b1;

   localparam logic                     POLICY_RST = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0] FRAMES_RST = 8'd128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EMPTY,
      ST_CLOCK,
      ST_READ,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ sv/prfc_page_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prfc_page_store
// Resident page table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prfc_page_store #(
   parameter int DEPTH = prfc_pkg::FRAMES_DEF,
   parameter int WIDTH = prfc_pkg::PAGE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/page_replacement_fifo_clock_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_replacement_fifo_clock_core
// Fully associative page lookup with FIFO or clock second-chance victim
// selection, stepped one frame per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | word
//  req_     | in  | req_valid/req_ready  | page_number
//  rsp_     | out | rsp_valid/rsp_ready  | hit, frame_slot, evicted_valid/page
//  csr_     | in  | csr_we               | index 0 policy, 1 frames_in_use
//
//  The lookup walks the page store one read per cycle, then the empty scan
//  and clock sweep step one slot per cycle on one shared incrementer.
//  Reset clears all valid and reference bits at once; no clearing pass.
//  A new word is taken once the previous one is in the output register,
//  even while that result still waits for rsp_ready.
// ----------------------------------------------------------------------------
module page_replacement_fifo_clock_core #(
   parameter int FRAMES    = prfc_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = prfc_pkg::PAGE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [PAGE_BITS-1:0]               req_page_number,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_hit,
   output logic      [prfc_pkg::SLOT_BITS-1:0]     rsp_frame_slot,
   output logic                                    rsp_evicted_valid,
   output logic      [PAGE_BITS-1:0]               rsp_evicted_page,
   input  wire logic                               csr_we,
   input  wire logic [prfc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [prfc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int SW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES + 1);
   localparam int NW = (CW > prfc_pkg::CSR_DATA_BITS) ? CW : prfc_pkg::CSR_DATA_BITS;

   prfc_pkg::state_type state_ff, state_in;

   logic                               policy_ff, policy_in;
   logic [prfc_pkg::CSR_DATA_BITS-1:0] frames_ff, frames_in;
   logic [FRAMES-1:0]                  valid_ff, valid_in;
   logic [FRAMES-1:0]                  ref_ff, ref_in;
   logic [SW-1:0]                      hand_ff, hand_in;
   logic [PAGE_BITS-1:0]               page_ff, page_in;
   logic [CW-1:0]                      idx_ff, idx_in;
   logic [SW-1:0]                      rd_idx_ff, rd_idx_in;
   logic                               rd_v_ff, rd_v_in;
   logic [SW-1:0]                      s_ff, s_in;
   logic [CW-1:0]                      i_ff, i_in;
   logic [SW-1:0]                      victim_ff, victim_in;
   logic                               hit_ff, hit_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic                               rsp_hit_ff;
   logic [prfc_pkg::SLOT_BITS-1:0]     rsp_slot_ff;
   logic                               rsp_ev_ff;
   logic [PAGE_BITS-1:0]               rsp_page_ff;

   logic                               mem_rd_en, mem_wr_en;
   logic [SW-1:0]                      mem_rd_addr;
   logic [PAGE_BITS-1:0]               mem_rd_data;

   logic [NW-1:0]                      frames_w, n_w;
   logic [CW-1:0]                      n;
   logic [SW-1:0]                      start;
   logic [SW-1:0]                      step_opnd, step_next;
   logic [CW-1:0]                      step_sum;
   logic                               issue, look_hit, out_free, load_rsp, ev;

   prfc_page_store #(
      .DEPTH (FRAMES),
      .WIDTH (PAGE_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (victim_ff),
      .wr_data (page_ff)
   );

   // active frame count and clamped start slot
   always_comb begin
      frames_w = NW'(frames_ff);
      if (frames_w == '0) begin
         n_w = NW'(1);
      end else if (frames_w > NW'(FRAMES)) begin
         n_w = NW'(FRAMES);
      end else begin
         n_w = frames_w;
      end
      n     = CW'(n_w);
      start = (CW'(hand_ff) >= n) ? '0 : hand_ff;
   end

   // shared wrap-around slot incrementer
   assign step_opnd = (state_ff == prfc_pkg::ST_DONE) ? victim_ff : s_ff;
   assign step_sum  = CW'(step_opnd) + CW'(1);
   assign step_next = (step_sum >= n) ? '0 : step_sum[SW-1:0];

   assign issue    = (idx_ff < n);
   assign look_hit = rd_v_ff && valid_ff[rd_idx_ff] && (mem_rd_data == page_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ev       = !hit_ff && valid_ff[victim_ff];

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      frames_in    = frames_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      hand_in      = hand_ff;
      page_in      = page_ff;
      idx_in       = idx_ff;
      rd_idx_in    = rd_idx_ff;
      rd_v_in      = 1'b0;
      s_in         = s_ff;
      i_in         = i_ff;
      victim_in    = victim_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[SW-1:0];
      mem_wr_en    = 1'b0;
      load_rsp     = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            prfc_pkg::CSR_POLICY: policy_in = csr_wdata[0];
            prfc_pkg::CSR_FRAMES: frames_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         prfc_pkg::ST_IDLE: begin
            if (req_valid) begin
               page_in  = req_page_number;
               idx_in   = '0;
               state_in = prfc_pkg::ST_LOOK;
            end
         end
         prfc_pkg::ST_LOOK: begin
            mem_rd_en = issue;
            rd_idx_in = idx_ff[SW-1:0];
            rd_v_in   = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (look_hit) begin
               victim_in = rd_idx_ff;
               hit_in    = 1'b1;
               state_in  = prfc_pkg::ST_DONE;
            end else if (idx_ff == n) begin
               hit_in   = 1'b0;
               s_in     = start;
               i_in     = '0;
               state_in = prfc_pkg::ST_EMPTY;
            end
         end
         prfc_pkg::ST_EMPTY: begin
            if (!valid_ff[s_ff]) begin
               victim_in = s_ff;
               state_in  = prfc_pkg::ST_READ;
            end else if (i_ff == n - CW'(1)) begin
               if (policy_ff) begin
                  s_in     = start;
                  state_in = prfc_pkg::ST_CLOCK;
               end else begin
                  victim_in = start;
                  state_in  = prfc_pkg::ST_READ;
               end
            end else begin
               s_in = step_next;
               i_in = i_ff + CW'(1);
            end
         end
         prfc_pkg::ST_CLOCK: begin
            if (!ref_ff[s_ff]) begin
               victim_in = s_ff;
               state_in  = prfc_pkg::ST_READ;
            end else begin
               ref_in[s_ff] = 1'b0;
               s_in         = step_next;
            end
         end
         prfc_pkg::ST_READ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = victim_ff;
            state_in    = prfc_pkg::ST_DONE;
         end
         prfc_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = prfc_pkg::ST_IDLE;
               if (hit_ff) begin
                  if (policy_ff) begin
                     ref_in[victim_ff] = 1'b1;
                  end
               end else begin
                  mem_wr_en           = 1'b1;
                  valid_in[victim_ff] = 1'b1;
                  ref_in[victim_ff]   = 1'b1;
                  hand_in             = step_next;
               end
            end
         end
         default: state_in = prfc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prfc_pkg::ST_IDLE;
         policy_ff    <= prfc_pkg::POLICY_RST;
         frames_ff    <= prfc_pkg::FRAMES_RST;
         valid_ff     <= '0;
         ref_ff       <= '0;
         hand_ff      <= '0;
         idx_ff       <= '0;
         rd_v_ff      <= 1'b0;
         s_ff         <= '0;
         i_ff         <= '0;
         victim_ff    <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         frames_ff    <= frames_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         hand_ff      <= hand_in;
         idx_ff       <= idx_in;
         rd_v_ff      <= rd_v_in;
         s_ff         <= s_in;
         i_ff         <= i_in;
         victim_ff    <= victim_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      rd_idx_ff <= rd_idx_in;
      if (load_rsp) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= prfc_pkg::SLOT_BITS'(victim_ff);
         rsp_ev_ff   <= ev;
         rsp_page_ff <= ev ? mem_rd_data : '0;
      end
   end

   assign req_ready         = (state_ff == prfc_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = rsp_page_ff;

`ifndef SYNTHESIS
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("hit word reports an eviction");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accepting a word");

   a_clock_needs_policy: assert property (@(posedge clock) disable iff (reset)
      state_ff == prfc_pkg::ST_CLOCK |-> policy_ff)
      else $error("clock sweep entered in FIFO mode");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO / clock second-chance page replacement
// core. A queue of page words and register writes feeds a valid/ready
// driver; a monitor runs a local model of the frame store on every accepted
// page and compares each result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int PAGE_W         = prfc_pkg::PAGE_BITS_DEF;
   localparam int FRAMES_N       = prfc_pkg::FRAMES_DEF;
   localparam int SLOT_W         = prfc_pkg::SLOT_BITS;
   localparam int IDX_W          = prfc_pkg::CSR_IDX_BITS;
   localparam int CSR_W          = prfc_pkg::CSR_DATA_BITS;
   localparam int RANDOM_PAGES   = 1500;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 3 * FRAMES_N + 20;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum {OP_PAGE, OP_CSR, OP_DRAIN} stim_kind_type;

   typedef struct {
      stim_kind_type     kind;
      logic [PAGE_W-1:0] page;
      logic [IDX_W-1:0]  index;
      logic [CSR_W-1:0]  data;
   } stim_word_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              evicted;
      logic [PAGE_W-1:0] evicted_page;
   } page_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [PAGE_W-1:0] req_page_number = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_frame_slot;
   logic              rsp_evicted_valid;
   logic [PAGE_W-1:0] rsp_evicted_page;
   logic              csr_we = 1'b0;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   stim_word_type   stim_q[$];
   page_result_type expected_q[$];

   // frame store model
   logic [PAGE_W-1:0] page_store [FRAMES_N];
   bit                slot_used  [FRAMES_N];
   bit                slot_ref   [FRAMES_N];
   int                hand = 0;
   bit                clock_mode = prfc_pkg::POLICY_RST;
   logic [CSR_W-1:0]  frames_cfg = prfc_pkg::FRAMES_RST;

   logic req_fire = 1'b0;
   int   pages_accepted = 0;
   int   results_seen = 0;
   int   mismatch_count = 0;
   int   settle_cnt = 0;
   int   idle_cycles = 0;
   bit   quiet_run;

   page_replacement_fifo_clock_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int active_frames(input logic [CSR_W-1:0] cfg);
      if (cfg == 0) return 1;
      if (cfg > FRAMES_N) return FRAMES_N;
      return int'(cfg);
   endfunction

   function automatic page_result_type replace_page(input logic [PAGE_W-1:0] page);
      page_result_type r;
      int n, start, s, victim, i;
      bit found;
      r = '0;
      n = active_frames(frames_cfg);
      start = (hand >= n) ? 0 : hand;
      for (i = 0; i < n; i++) begin
         if (slot_used[i] && page_store[i] == page) begin
            if (clock_mode) slot_ref[i] = 1'b1;
            r.hit = 1'b1;
            r.slot = i[SLOT_W-1:0];
            return r;
         end
      end
      found = 1'b0;
      victim = start;
      s = start;
      for (i = 0; i < n; i++) begin
         if (!slot_used[s]) begin
            victim = s;
            found = 1'b1;
            break;
         end
         s = (s + 1 >= n) ? 0 : s + 1;
      end
      if (!found && clock_mode) begin
         s = start;
         for (i = 0; i <= n; i++) begin
            if (!slot_ref[s]) break;
            slot_ref[s] = 1'b0;
            s = (s + 1 >= n) ? 0 : s + 1;
         end
         victim = s;
      end
      r.slot = victim[SLOT_W-1:0];
      if (slot_used[victim]) begin
         r.evicted = 1'b1;
         r.evicted_page = page_store[victim];
      end
      page_store[victim] = page;
      slot_used[victim] = 1'b1;
      slot_ref[victim] = 1'b1;
      hand = (victim + 1 >= n) ? 0 : victim + 1;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at word %0d: %s got %0d want %0d", results_seen, what, got, want);
   endtask

   task automatic push_page(input logic [PAGE_W-1:0] page);
      stim_word_type w;
      w.kind = OP_PAGE;
      w.page = page;
      w.index = '0;
      w.data = '0;
      stim_q.push_back(w);
   endtask

   task automatic reconfigure(input bit pol, input logic [CSR_W-1:0] frames);
      stim_word_type w;
      w.page = '0;
      w.kind = OP_DRAIN;
      w.index = '0;
      w.data = '0;
      stim_q.push_back(w);
      w.kind = OP_CSR;
      w.index = prfc_pkg::CSR_POLICY;
      w.data = {{(CSR_W-1){1'b0}}, pol};
      stim_q.push_back(w);
      w.index = prfc_pkg::CSR_FRAMES;
      w.data = frames;
      stim_q.push_back(w);
   endtask

   assign quiet_run = (pages_accepted >= 700) && (pages_accepted < 1000);

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         rsp_ready <= quiet_run || ($urandom_range(99) >= 30);
         if (req_valid && !req_fire) begin
            csr_we <= 1'b0;
         end else if (stim_q.size() == 0) begin
            req_valid <= 1'b0;
            csr_we <= 1'b0;
         end else if (stim_q[0].kind == OP_DRAIN) begin
            req_valid <= 1'b0;
            csr_we <= 1'b0;
            if (expected_q.size() == 0 && !req_valid && !rsp_valid) begin
               if (settle_cnt >= SETTLE_CYCLES) begin
                  settle_cnt <= 0;
                  void'(stim_q.pop_front());
               end else begin
                  settle_cnt <= settle_cnt + 1;
               end
            end else begin
               settle_cnt <= 0;
            end
         end else if (stim_q[0].kind == OP_CSR) begin
            req_valid <= 1'b0;
            csr_we <= 1'b1;
            csr_index <= stim_q[0].index;
            csr_wdata <= stim_q[0].data;
            void'(stim_q.pop_front());
         end else if (!quiet_run && $urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            csr_we <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_page_number <= stim_q[0].page;
            csr_we <= 1'b0;
            void'(stim_q.pop_front());
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      page_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_we) begin
            case (csr_index)
               prfc_pkg::CSR_POLICY: clock_mode = csr_wdata[0];
               prfc_pkg::CSR_FRAMES: frames_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_q.push_back(replace_page(req_page_number));
            pages_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected word, slot", int'(rsp_frame_slot), 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", int'(rsp_hit), int'(want.hit));
               if (rsp_frame_slot !== want.slot)
                  report_mismatch("frame_slot", int'(rsp_frame_slot), int'(want.slot));
               if (rsp_evicted_valid !== want.evicted)
                  report_mismatch("evicted_valid", int'(rsp_evicted_valid),
                                  int'(want.evicted));
               if (rsp_evicted_page !== want.evicted_page)
                  report_mismatch("evicted_page", int'(rsp_evicted_page),
                                  int'(want.evicted_page));
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int random_pages, phase, eff, pool, batch, k;
      bit pol;
      logic [CSR_W-1:0] frames;
      logic [PAGE_W-1:0] base;

      for (k = 0; k < FRAMES_N; k++) begin
         page_store[k] = '0;
         slot_used[k] = 1'b0;
         slot_ref[k] = 1'b0;
      end

      // clock mode, four frames: fill, full sweep, second chance skip
      reconfigure(1'b1, 8'd4);
      push_page(12'd0);
      push_page(12'hFFF);
      push_page(12'd0);
      push_page(12'h800);
      push_page(12'd1);
      push_page(12'd5);
      push_page(12'hFFF);
      push_page(12'd7);
      // zero frames acts as one, hand past the active range
      reconfigure(1'b1, 8'd0);
      push_page(12'd5);
      push_page(12'd9);
      push_page(12'd9);
      // FIFO, count above the store size, empty frames filled first
      reconfigure(1'b0, 8'd255);
      push_page(12'hFFF);
      push_page(12'd10);
      push_page(12'd10);
      push_page(12'hAAA);
      push_page(12'h555);
      // FIFO on two frames: victim at the hand, reference bits ignored
      reconfigure(1'b0, 8'd2);
      push_page(12'd3);
      push_page(12'hFFF);
      push_page(12'd6);
      push_page(12'd3);
      // regrow: pages parked in inactive frames hit again
      reconfigure(1'b1, 8'd8);
      push_page(12'd10);
      push_page(12'hAAA);
      push_page(12'd7);
      push_page(12'd4000);

      random_pages = 0;
      phase = 0;
      while (random_pages < RANDOM_PAGES) begin
         if (phase == 0) frames = 8'd128;
         else if (phase == 1) frames = 8'd1;
         else begin
            case ($urandom_range(9))
               0: frames = 8'd0;
               1: frames = CSR_W'($urandom_range(129, 255));
               2: frames = 8'd128;
               default: frames = CSR_W'($urandom_range(2, 16));
            endcase
         end
         pol = 1'($urandom_range(1));
         reconfigure(pol, frames);
         eff = active_frames(frames);
         pool = eff + int'($urandom_range(1, eff / 2 + 3));
         base = PAGE_W'($urandom_range(4095));
         batch = (eff > 16) ? int'($urandom_range(60, 100)) : int'($urandom_range(40, 120));
         for (k = 0; k < batch; k++) begin
            if ($urandom_range(9) == 0)
               push_page(PAGE_W'($urandom_range(4095)));
            else
               push_page(PAGE_W'(base + $urandom_range(pool - 1)));
         end
         random_pages += batch;
         phase++;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
         #1;
      end while (stim_q.size() != 0 || expected_q.size() != 0 || req_valid);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("words still expected", 0, expected_q.size());

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/prfc_pkg.sv
sv/prfc_page_store.sv
sv/page_replacement_fifo_clock_core.sv
sim/tb_top.sv
